// ----- src/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search core:
// the control word layout, the step and condition codes, and the
// control store contents.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

   // field widths fixed by the item format
   localparam int KEY_W   = 32;
   localparam int EIDX_W  = 7;
   localparam int COUNT_W = 8;

   // command codes of an input item
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // configuration register byte addresses
   localparam logic [2:0] ADDR_ENTRY_COUNT = 3'd0;

   // step codes of the control program
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd1;
   localparam logic [STEP_W-1:0] STEP_PROBE    = 3'd2;
   localparam logic [STEP_W-1:0] STEP_CMP      = 3'd3;
   localparam logic [STEP_W-1:0] STEP_WRITE    = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT     = 3'd5;

   // branch condition codes
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd0;
   localparam logic [COND_W-1:0] COND_REQ      = 3'd1;
   localparam logic [COND_W-1:0] COND_WRITE    = 3'd2;
   localparam logic [COND_W-1:0] COND_EMPTY    = 3'd3;
   localparam logic [COND_W-1:0] COND_MATCH    = 3'd4;
   localparam logic [COND_W-1:0] COND_OUT_FREE = 3'd5;

   // one control word per step
   typedef struct packed {
      logic              take;   // accept an input item
      logic              wr;     // write key into the table
      logic              rd;     // read the table at mid
      logic              upd;    // apply compare result to the range
      logic              emit;   // load the result register
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] tgt_t;  // next step when cond holds
      logic [STEP_W-1:0] tgt_f;  // next step otherwise
   } ctl_word_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic is_write;
      logic empty;
      logic match;
      logic out_free;
   } ctl_status_type;

   // control store
   function automatic ctl_word_type ctl_rom(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      w = '0;
      case (step)
         STEP_IDLE: begin
            w.take = 1'b1; w.cond = COND_REQ;
            w.tgt_t = STEP_DISPATCH; w.tgt_f = STEP_IDLE;
         end
         STEP_DISPATCH: begin
            w.cond = COND_WRITE;
            w.tgt_t = STEP_WRITE; w.tgt_f = STEP_PROBE;
         end
         STEP_PROBE: begin
            w.rd = 1'b1; w.cond = COND_EMPTY;
            w.tgt_t = STEP_EMIT; w.tgt_f = STEP_CMP;
         end
         STEP_CMP: begin
            w.upd = 1'b1; w.cond = COND_MATCH;
            w.tgt_t = STEP_EMIT; w.tgt_f = STEP_PROBE;
         end
         STEP_WRITE: begin
            w.wr = 1'b1; w.cond = COND_ALWAYS;
            w.tgt_t = STEP_EMIT; w.tgt_f = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit = 1'b1; w.cond = COND_OUT_FREE;
            w.tgt_t = STEP_IDLE; w.tgt_f = STEP_EMIT;
         end
         default: begin
            w.cond = COND_ALWAYS;
            w.tgt_t = STEP_IDLE; w.tgt_f = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- src/stbs_sequencer.sv -----
// ----------------------------------------------------------------------------
// stbs_sequencer
// Step counter and control store. Each step issues one control word and
// branches on one selected status condition.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_sequencer
   import stbs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire ctl_status_type status,
   output ctl_word_type        ctl
);

   logic [STEP_W-1:0] upc_ff;
   logic [STEP_W-1:0] upc_in;
   logic              cond_hit;

   assign ctl = ctl_rom(upc_ff);

   // condition select
   always_comb begin
      case (ctl.cond)
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_REQ:      cond_hit = status.req_valid;
         COND_WRITE:    cond_hit = status.is_write;
         COND_EMPTY:    cond_hit = status.empty;
         COND_MATCH:    cond_hit = status.match;
         COND_OUT_FREE: cond_hit = status.out_free;
         default:       cond_hit = 1'b1;
      endcase
   end

   assign upc_in = cond_hit ? ctl.tgt_t : ctl.tgt_f;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/stbs_datapath.sv -----
// ----------------------------------------------------------------------------
// stbs_datapath
// Item registers, key table memory, search range registers, key compare
// and result register, all driven by the current control word.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_datapath
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = 128
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctl_word_type             ctl,
   output ctl_status_type                status,
   input  wire logic [COUNT_W-1:0]       entry_count,
   input  wire logic                     req_valid,
   input  wire logic                     req_command,
   input  wire logic [EIDX_W-1:0]        req_entry_index,
   input  wire logic signed [KEY_W-1:0]  req_key,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_found,
   output logic [EIDX_W-1:0]             rsp_found_index
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int WID_W = IDX_W + EIDX_W;

   // item registers
   logic                    cmd_ff;
   logic [EIDX_W-1:0]       widx_ff;
   logic signed [KEY_W-1:0] key_ff;

   // search range: low..hi1-1, empty when low >= hi1
   logic [CNT_W-1:0]        low_ff,   low_in;
   logic [CNT_W-1:0]        hi1_ff,   hi1_in;
   logic [CNT_W-1:0]        mid_ff;
   logic                    found_ff, found_in;
   logic signed [KEY_W-1:0] probe_ff;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff;
   logic [EIDX_W-1:0]       rsp_index_ff;

   logic [KEY_W-1:0]        key_mem [TABLE_DEPTH];

   logic                    accept;
   logic                    out_free;
   logic                    load_rsp;
   logic [CMP_W-1:0]        count_ext;
   logic [CNT_W-1:0]        span;
   logic [CNT_W:0]          mid_sum;
   logic [CNT_W-1:0]        mid;
   logic [WID_W-1:0]        widx_ext;
   logic                    widx_ok;
   logic [WID_W-1:0]        mid_ext;
   logic                    match;

   assign accept   = ctl.take & req_valid;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign load_rsp = ctl.emit & out_free;

   // entries in use, clipped to the table size
   assign count_ext = CMP_W'(entry_count);
   assign span = (count_ext > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                   : count_ext[CNT_W-1:0];

   // mid = (low + high) / 2 with high = hi1 - 1
   assign mid_sum = {1'b0, low_ff} + {1'b0, hi1_ff} - (CNT_W+1)'(1);
   assign mid     = mid_sum[CNT_W:1];

   // write address check
   assign widx_ext = WID_W'(widx_ff);
   assign widx_ok  = widx_ext < WID_W'(TABLE_DEPTH);

   assign match   = (probe_ff == key_ff);
   assign mid_ext = WID_W'(mid_ff);

   assign status.req_valid = req_valid;
   assign status.is_write  = (cmd_ff == CMD_WRITE);
   assign status.empty     = ~(low_ff < hi1_ff);
   assign status.match     = match;
   assign status.out_free  = out_free;

   // range and found flag update
   always_comb begin
      low_in   = low_ff;
      hi1_in   = hi1_ff;
      found_in = found_ff;
      if (accept) begin
         low_in   = '0;
         hi1_in   = span;
         found_in = 1'b0;
      end else if (ctl.upd) begin
         if (match) begin
            found_in = 1'b1;
         end else if (probe_ff < key_ff) begin
            low_in = mid_ff + CNT_W'(1);
         end else begin
            hi1_in = mid_ff;
         end
      end
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      hi1_ff   <= hi1_in;
      found_ff <= found_in;
      if (accept) begin
         cmd_ff  <= req_command;
         widx_ff <= req_entry_index;
         key_ff  <= req_key;
      end
      if (ctl.rd) begin
         mid_ff <= mid;
      end
      if (load_rsp) begin
         rsp_found_ff <= found_ff;
         rsp_index_ff <= found_ff ? mid_ext[EIDX_W-1:0] : '0;
      end
   end

   // key table, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (ctl.wr && widx_ok) begin
         key_mem[widx_ext[IDX_W-1:0]] <= key_ff;
      end
      if (ctl.rd) begin
         probe_ff <= key_mem[mid[IDX_W-1:0]];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_index_ff;

endmodule

`default_nettype wire

// ----- src/sorted_table_binary_search_core.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Sorted key table with binary search. Write items load table entries,
// search items probe the table by halving the index range.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  command, entry_index, key
//   rsp      out        rsp_valid / rsp_stall  found, found_index
//   csr      in/out     APB psel / penable     entry_count at address 0
//
// A write item steps idle, dispatch, write, emit. A search steps idle,
// dispatch, p probe/compare pairs, on a miss an empty-range probe, emit, with
// p at most floor(log2(n)) + 1 for n = entry_count clipped to TABLE_DEPTH.
// Reset clears the step counter, result valid and entry_count; the table
// holds no reset value. A stalled result holds the sequencer in its last
// step, and no new item is taken until the result register is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search_core
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = 128
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_command,
   input  wire logic [EIDX_W-1:0]        req_entry_index,
   input  wire logic signed [KEY_W-1:0]  req_key,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_found,
   output logic [EIDX_W-1:0]             rsp_found_index,
   // configuration port
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [2:0]               paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               count_sel;
   ctl_word_type       ctl;
   ctl_status_type     status;

   // configuration register
   assign pready    = 1'b1;
   assign count_sel = (paddr[2] == ADDR_ENTRY_COUNT[2]);
   assign count_in  = (psel && penable && pwrite && count_sel) ? pwdata[COUNT_W-1:0]
                                                               : count_ff;
   assign prdata    = count_sel ? 32'(count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign req_stall = ~ctl.take;

   stbs_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .status          (status),
      .entry_count     (count_ff),
      .req_valid       (req_valid),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index)
   );

endmodule

`default_nettype wire
